// File: rtl/g2pbf_pkg.sv
// Shared types and codes for the G2 packet byte framer.
package g2pbf_pkg;

    // Byte kind codes, also used as the framer phase
    localparam logic [1:0] KIND_CONTROL = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_NAME    = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    // Control byte fields
    localparam int unsigned CTL_LEN_MSB  = 7;
    localparam int unsigned CTL_LEN_LSB  = 6;
    localparam int unsigned CTL_NAME_MSB = 5;
    localparam int unsigned CTL_NAME_LSB = 3;
    localparam int unsigned CTL_COMPOUND = 2;
    localparam int unsigned CTL_BIG_END  = 1;

    localparam int unsigned LEN_W = 24;

    // One result item
    typedef struct packed {
        logic [7:0]       byte_value;
        logic [1:0]       byte_kind;
        logic [3:0]       name_len;
        logic [LEN_W-1:0] pay_len;
        logic             is_compound;
        logic             is_big_endian;
        logic             header_done;
        logic             packet_end;
    } t_result;

endpackage

// File: rtl/g2pbf_parse.sv
// Framer state and per-byte decode: tags each byte and tracks packet phase.
module g2pbf_parse
    import g2pbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_len_left, n_len_left;
    logic [1:0]       r_len_idx, n_len_idx;
    logic [2:0]       r_name_left, n_name_left;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic [LEN_W-1:0] r_pay_left, n_pay_left;
    logic [2:0]       r_name_len, n_name_len;
    logic             r_compound, n_compound;
    logic             r_big_end, n_big_end;
    logic             hdr;
    logic             pend;
    logic [LEN_W-1:0] le_byte;

    // Place a little-endian length byte at its lane
    always_comb begin
        le_byte = '0;
        case (r_len_idx)
            2'd0:    le_byte[7:0]   = i_byte;
            2'd1:    le_byte[15:8]  = i_byte;
            2'd2:    le_byte[23:16] = i_byte;
            default: le_byte        = '0;
        endcase
    end

    // Decode the byte against the current phase
    always_comb begin
        n_phase     = r_phase;
        n_len_left  = r_len_left;
        n_len_idx   = r_len_idx;
        n_name_left = r_name_left;
        n_accum     = r_accum;
        n_pay_left  = r_pay_left;
        n_name_len  = r_name_len;
        n_compound  = r_compound;
        n_big_end   = r_big_end;
        hdr         = 1'b0;
        pend        = 1'b0;
        unique case (r_phase)
            KIND_CONTROL: begin
                n_len_left  = i_byte[CTL_LEN_MSB:CTL_LEN_LSB];
                n_name_len  = i_byte[CTL_NAME_MSB:CTL_NAME_LSB];
                n_name_left = i_byte[CTL_NAME_MSB:CTL_NAME_LSB];
                n_compound  = i_byte[CTL_COMPOUND];
                n_big_end   = i_byte[CTL_BIG_END];
                n_len_idx   = '0;
                n_accum     = '0;
                n_pay_left  = '0;
                n_phase     = (i_byte[CTL_LEN_MSB:CTL_LEN_LSB] != 2'd0) ? KIND_LENGTH
                                                                        : KIND_NAME;
            end
            KIND_LENGTH: begin
                if (r_big_end) begin
                    n_accum = {r_accum[LEN_W-9:0], i_byte};
                end else begin
                    n_accum = r_accum | le_byte;
                end
                n_len_idx  = r_len_idx + 2'd1;
                n_len_left = r_len_left - 2'd1;
                if (r_len_left == 2'd1) begin
                    n_phase = KIND_NAME;
                end
            end
            KIND_NAME: begin
                if (r_name_left == 3'd0) begin
                    hdr        = 1'b1;
                    n_pay_left = r_accum;
                    if (r_accum == '0) begin
                        pend    = 1'b1;
                        n_phase = KIND_CONTROL;
                    end else begin
                        n_phase = KIND_PAYLOAD;
                    end
                end else begin
                    n_name_left = r_name_left - 3'd1;
                end
            end
            KIND_PAYLOAD: begin
                n_pay_left = r_pay_left - LEN_W'(1);
                if (r_pay_left == LEN_W'(1)) begin
                    pend    = 1'b1;
                    n_phase = KIND_CONTROL;
                end
            end
            default: n_phase = KIND_CONTROL;
        endcase
    end

    // Build the result item from the current phase and the updated state
    always_comb begin
        o_result.byte_value    = i_byte;
        o_result.byte_kind     = r_phase;
        o_result.name_len      = {1'b0, n_name_len} + 4'd1;
        o_result.pay_len       = n_accum;
        o_result.is_compound   = n_compound;
        o_result.is_big_endian = n_big_end;
        o_result.header_done   = hdr;
        o_result.packet_end    = pend;
    end

    // Advance state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= KIND_CONTROL;
            r_len_left  <= '0;
            r_len_idx   <= '0;
            r_name_left <= '0;
            r_accum     <= '0;
            r_pay_left  <= '0;
            r_name_len  <= '0;
            r_compound  <= 1'b0;
            r_big_end   <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_len_left  <= n_len_left;
            r_len_idx   <= n_len_idx;
            r_name_left <= n_name_left;
            r_accum     <= n_accum;
            r_pay_left  <= n_pay_left;
            r_name_len  <= n_name_len;
            r_compound  <= n_compound;
            r_big_end   <= n_big_end;
        end
    end

    // A control byte never leaves the framer expecting another control byte
    a_ctl_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == KIND_CONTROL |=> r_phase != KIND_CONTROL)
        else $error("control byte did not advance phase");

    // Payload phase always has bytes outstanding
    a_pay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == KIND_PAYLOAD |-> r_pay_left != '0)
        else $error("payload phase with no bytes left");

    // Length phase always has length bytes outstanding
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == KIND_LENGTH |-> r_len_left != 2'd0)
        else $error("length phase with no bytes left");

    // Taken plus outstanding length bytes never exceeds the field size
    a_len_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_len_idx} + {1'b0, r_len_left}) <= 3'd3)
        else $error("length byte count overflow");

endmodule

// File: rtl/g2pbf_out_reg.sv
// Result register between the framer decode and the output channel.
module g2pbf_out_reg
    import g2pbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_full_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Hold the item while the receiver stalls
    assign o_full_stall = r_valid & i_stall;
    assign o_valid      = r_valid;
    assign o_result     = r_result;

    // Load a new item, or drop the valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/g2_packet_byte_framer.sv
// G2 packet byte framer top level.
//
// Input channel: i_valid / o_stall carry one stream byte per item on i_byte_in.
// Output channel: o_valid / i_stall carry one result item per input byte: the
// byte itself, its kind (control, length, name, payload), the current name
// length, flags and the decoded payload length, plus header_done on the last
// name byte and packet_end on the last byte of each packet.
// A taken byte is registered and offered on the output in the next cycle.
// One byte per clock unless stalled; the phase update is a single pass of
// decode logic on the framer state register, feeding one result register.
// When the receiver stalls with a result held, o_stall rises in the same
// cycle and the held item stays unchanged until taken; otherwise a new byte
// is taken every cycle even while the previous result is being delivered.
// Synchronous active-low reset empties the result register and returns the
// framer to expecting a control byte with zero length and flags.
module g2_packet_byte_framer
    import g2pbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_byte_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_byte_value,
    output logic [1:0]       o_byte_kind,
    output logic [3:0]       o_name_len,
    output logic [LEN_W-1:0] o_pay_len,
    output logic             o_is_compound,
    output logic             o_is_big_endian,
    output logic             o_header_done,
    output logic             o_packet_end
);

    logic    accept;
    logic    full_stall;
    t_result dec_result;
    t_result out_result;

    assign o_stall = full_stall;
    assign accept  = i_valid & ~full_stall;

    // Decode each accepted byte
    g2pbf_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte_in),
        .o_result (dec_result)
    );

    // Register the result item
    g2pbf_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_result     (dec_result),
        .i_stall      (i_stall),
        .o_full_stall (full_stall),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_byte_value    = out_result.byte_value;
    assign o_byte_kind     = out_result.byte_kind;
    assign o_name_len      = out_result.name_len;
    assign o_pay_len       = out_result.pay_len;
    assign o_is_compound   = out_result.is_compound;
    assign o_is_big_endian = out_result.is_big_endian;
    assign o_header_done   = out_result.header_done;
    assign o_packet_end    = out_result.packet_end;

endmodule
